// ===== src/mvbf_pkg.sv =====
// Shared types, character codes and tag patterns of the markup variant filter.
package mvbf_pkg;

  // Character codes of the tag delimiters.
  localparam logic [7:0] CHAR_LT = 8'h3C;
  localparam logic [7:0] CHAR_GT = 8'h3E;

  // Lengths of the patterns that are matched at the start of a tag.
  localparam int OPENER_LEN = 28;
  localparam int CLOSER_LEN = 4;
  localparam int PAT_IDX_W  = 5;

  // Variant openers and the closing pattern, first character in the top byte.
  localparam logic [8*OPENER_LEN-1:0] OPENER_ONE = "div type=\"variant\" class=\"1\"";
  localparam logic [8*OPENER_LEN-1:0] OPENER_TWO = "div type=\"variant\" class=\"2\"";
  localparam logic [8*CLOSER_LEN-1:0] CLOSER_PAT = "/div";

  // Register index of the mode register on the configuration port.
  localparam logic REG_VARIANT_MODE = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;       // an input item is accepted this cycle
    logic load_lt;    // load the opening bracket of a re-emitted tag
    logic load_body;  // load the fetched tag byte
    logic load_gt;    // load the closing bracket and release the tag
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pass_byte;  // the waiting input item yields itself as one result
    logic emit_tag;   // the waiting input item re-emits the buffered tag
    logic out_free;   // the output register can be loaded this cycle
    logic tag_empty;  // no bytes are buffered
    logic idx_last;   // the read index points at the last buffered byte
  } dp_status_t;

  // Character of the first variant opener at a given position.
  function automatic logic [7:0] opener_one_char(input logic [PAT_IDX_W-1:0] pos);
    return OPENER_ONE[8*(OPENER_LEN-1-int'(pos)) +: 8];
  endfunction

  // Character of the second variant opener at a given position.
  function automatic logic [7:0] opener_two_char(input logic [PAT_IDX_W-1:0] pos);
    return OPENER_TWO[8*(OPENER_LEN-1-int'(pos)) +: 8];
  endfunction

  // Character of the closing pattern at a given position.
  function automatic logic [7:0] closer_char(input logic [1:0] pos);
    return CLOSER_PAT[8*(CLOSER_LEN-1-int'(pos)) +: 8];
  endfunction

endpackage

// ===== src/markup_variant_block_filter.sv =====
// Markup variant filter: one input byte per item, zero or more filtered bytes out.
//
// Flow: a byte that passes as text, or is dropped, is taken while the controller
// is idle and the output register is free. A buffered tag that is re-emitted holds
// the input for the opening bracket, then for each buffered byte the registered read
// of the tag buffer and then the load of the output register, then the closing
// bracket. Bytes between '<' and '>' are collected in a buffer of TAG_BYTES entries;
// later bytes of a long tag are dropped and the re-emitted tag is marked truncated.
// The mode register must be written only while the block is idle; the block itself
// does not enforce this. No clearing pass follows reset.
module markup_variant_block_filter #(
  parameter int TAG_BYTES = 62
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // text_end
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // run_last
  output logic        m_axis_tuser,   // [0] tag_truncated
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]           variant_mode;
  logic                 reg_sel;
  mvbf_pkg::ctl_cmd_t   cmd;
  mvbf_pkg::dp_status_t status;

  // Register decode on the word address.
  assign reg_sel = (paddr[2] == mvbf_pkg::REG_VARIANT_MODE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {30'd0, variant_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      variant_mode <= 2'd0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      variant_mode <= pwdata[1:0];
    end
  end

  mvbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mvbf_datapath #(
    .TAG_BYTES (TAG_BYTES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .variant_mode  (variant_mode),
    .in_byte       (s_axis_tdata),
    .text_end      (s_axis_tlast),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (m_axis_tdata),
    .run_last      (m_axis_tlast),
    .tag_truncated (m_axis_tuser)
  );

endmodule

// ===== src/mvbf_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module mvbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 62
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/mvbf_ctrl.sv =====
// Controller of the markup variant filter: accepts items and sequences tag re-emission.
module mvbf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mvbf_pkg::dp_status_t  status,
  output mvbf_pkg::ctl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FETCH = 2'd1;
  localparam logic [1:0] ST_BODY  = 2'd2;
  localparam logic [1:0] ST_CLOSE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // An item is taken only in idle and only when the output register can take a result.
  assign in_ready = (state == ST_IDLE) && status.out_free;

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd.take      = 1'b0;
    cmd.load_lt   = 1'b0;
    cmd.load_body = 1'b0;
    cmd.load_gt   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take = 1'b1;
          if (status.emit_tag) begin
            cmd.load_lt = 1'b1;
            state_next  = status.tag_empty ? ST_CLOSE : ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_next = ST_BODY;
      end
      ST_BODY: begin
        if (status.out_free) begin
          cmd.load_body = 1'b1;
          state_next    = status.idx_last ? ST_CLOSE : ST_FETCH;
        end
      end
      ST_CLOSE: begin
        if (status.out_free) begin
          cmd.load_gt = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/mvbf_datapath.sv =====
// Datapath of the markup variant filter: tag state, tag buffer, pattern match and output register.
module mvbf_datapath #(
  parameter int TAG_BYTES = 62
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           variant_mode,
  input  logic [7:0]           in_byte,
  input  logic                 text_end,
  input  mvbf_pkg::ctl_cmd_t   cmd,
  output mvbf_pkg::dp_status_t status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 run_last,
  output logic                 tag_truncated
);

  localparam int IDX_W = $clog2(TAG_BYTES);
  localparam int CNT_W = $clog2(TAG_BYTES + 1);

  logic             inside_tag;
  logic             hiding;
  logic [CNT_W-1:0] tag_count;
  logic             overflowed;
  logic             match_one;
  logic             match_two;
  logic             match_close;
  logic [IDX_W-1:0] rd_idx;
  logic [7:0]       rd_byte;

  logic pass_mode;
  logic is_lt;
  logic is_gt;
  logic close_tag;
  logic hit_open;
  logic hit_close;
  logic has_room;
  logic store_byte;
  logic char_one_ok;
  logic char_two_ok;
  logic char_close_ok;

  // Decode of the waiting input item against the current tag state.
  assign pass_mode = variant_mode[1];
  assign is_lt     = (in_byte == mvbf_pkg::CHAR_LT);
  assign is_gt     = (in_byte == mvbf_pkg::CHAR_GT);
  assign close_tag = !pass_mode && is_gt && inside_tag;
  assign hit_open  = (tag_count >= CNT_W'(mvbf_pkg::OPENER_LEN)) &&
                     (variant_mode[0] ? match_two : match_one);
  assign hit_close = (tag_count >= CNT_W'(mvbf_pkg::CLOSER_LEN)) && match_close;
  assign has_room  = (tag_count < CNT_W'(TAG_BYTES));
  assign store_byte = cmd.take && !pass_mode && !is_lt && !close_tag && inside_tag && has_room;

  // Compare the incoming tag byte with each pattern at its position. Bytes past the
  // end of a pattern leave its match as it is.
  always_comb begin
    char_one_ok   = 1'b1;
    char_two_ok   = 1'b1;
    char_close_ok = 1'b1;
    if (tag_count < CNT_W'(mvbf_pkg::OPENER_LEN)) begin
      char_one_ok = (in_byte ==
                     mvbf_pkg::opener_one_char(tag_count[mvbf_pkg::PAT_IDX_W-1:0]));
      char_two_ok = (in_byte ==
                     mvbf_pkg::opener_two_char(tag_count[mvbf_pkg::PAT_IDX_W-1:0]));
    end
    if (tag_count < CNT_W'(mvbf_pkg::CLOSER_LEN)) begin
      char_close_ok = (in_byte == mvbf_pkg::closer_char(tag_count[1:0]));
    end
  end

  // Status towards the controller.
  assign status.pass_byte = pass_mode ||
                            (!is_lt && !inside_tag && !hiding);
  assign status.emit_tag  = close_tag && !hit_open && !hit_close && !hiding;
  assign status.out_free  = !out_valid || out_ready;
  assign status.tag_empty = (tag_count == '0);
  assign status.idx_last  = ((CNT_W+1)'(rd_idx) + (CNT_W+1)'(1)) == (CNT_W+1)'(tag_count);

  // Tag buffer.
  mvbf_ram #(
    .WIDTH (8),
    .DEPTH (TAG_BYTES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (store_byte),
    .waddr (tag_count[IDX_W-1:0]),
    .wdata (in_byte),
    .raddr (rd_idx),
    .rdata (rd_byte)
  );

  // Tag state: collection, matching, hiding and end of text.
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag  <= 1'b0;
      hiding      <= 1'b0;
      tag_count   <= '0;
      overflowed  <= 1'b0;
      match_one   <= 1'b1;
      match_two   <= 1'b1;
      match_close <= 1'b1;
    end else begin
      if (cmd.take) begin
        if (!pass_mode) begin
          if (is_lt) begin
            inside_tag  <= 1'b1;
            tag_count   <= '0;
            overflowed  <= 1'b0;
            match_one   <= 1'b1;
            match_two   <= 1'b1;
            match_close <= 1'b1;
          end else if (close_tag) begin
            inside_tag <= 1'b0;
            if (hit_open) begin
              hiding <= 1'b1;
            end else if (hit_close) begin
              hiding <= 1'b0;
            end
            // A tag that is re-emitted is released only after its closing bracket.
            if (!status.emit_tag) begin
              tag_count  <= '0;
              overflowed <= 1'b0;
            end
          end else if (inside_tag) begin
            if (has_room) begin
              tag_count   <= tag_count + CNT_W'(1);
              match_one   <= match_one && char_one_ok;
              match_two   <= match_two && char_two_ok;
              match_close <= match_close && char_close_ok;
            end else begin
              overflowed <= 1'b1;
            end
          end
        end
        // The end of the text drops the tag and hiding state; a re-emitted tag keeps its buffer.
        if (text_end) begin
          inside_tag <= 1'b0;
          hiding     <= 1'b0;
          if (!status.emit_tag) begin
            tag_count  <= '0;
            overflowed <= 1'b0;
          end
        end
      end
      if (cmd.load_gt) begin
        tag_count  <= '0;
        overflowed <= 1'b0;
      end
    end
  end

  // Read index over the buffered tag during re-emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
    end else if (cmd.take) begin
      rd_idx <= '0;
    end else if (cmd.load_body && !status.idx_last) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  // Output register: holds one result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.take && status.pass_byte) || cmd.load_lt || cmd.load_body ||
                 cmd.load_gt) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.load_lt) begin
      out_byte      <= mvbf_pkg::CHAR_LT;
      run_last      <= 1'b0;
      tag_truncated <= overflowed;
    end else if (cmd.take && status.pass_byte) begin
      out_byte      <= in_byte;
      run_last      <= 1'b1;
      tag_truncated <= 1'b0;
    end else if (cmd.load_body) begin
      out_byte      <= rd_byte;
      run_last      <= 1'b0;
      tag_truncated <= overflowed;
    end else if (cmd.load_gt) begin
      out_byte      <= mvbf_pkg::CHAR_GT;
      run_last      <= 1'b1;
      tag_truncated <= overflowed;
    end
  end

endmodule
